// File: rtl/nfps_pkg.sv
// nfps_pkg: shared types, codes and bus constants for the NOR flash program/erase sequencer
`default_nettype none
package nfps_pkg;

	localparam int ADDR_W             = 23;
	localparam int WORD_ADDR_BITS_DEF = 23;
	localparam int JOBQ_DEPTH_DEF     = 2;
	localparam int LIMIT_W            = 24;
	localparam logic [LIMIT_W-1:0] POLL_LIMIT_RST = 24'd10000000;

	localparam logic [2:0] CMD_ERASE   = 3'd0;
	localparam logic [2:0] CMD_PROGRAM = 3'd1;
	localparam logic [2:0] CMD_POLL    = 3'd2;
	localparam logic [2:0] CMD_RESET   = 3'd3;

	localparam logic [2:0] ST_NONE       = 3'd0;
	localparam logic [2:0] ST_BUSY       = 3'd1;
	localparam logic [2:0] ST_WORD_DONE  = 3'd2;
	localparam logic [2:0] ST_TIMEOUT    = 3'd3;
	localparam logic [2:0] ST_ERASE_DONE = 3'd4;
	localparam logic [2:0] ST_ERASE_ERR  = 3'd5;
	localparam logic [2:0] ST_REJECT     = 3'd6;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [15:0] FL_UNLOCK1  = 16'hAAAA;
	localparam logic [15:0] FL_UNLOCK2  = 16'h5555;
	localparam logic [15:0] FL_ERASE    = 16'h8080;
	localparam logic [15:0] FL_CHIP_ERS = 16'h1010;
	localparam logic [15:0] FL_PROGRAM  = 16'hA0A0;
	localparam logic [15:0] FL_RESET    = 16'hF0F0;
	localparam logic [15:0] DQ7_MASK    = 16'h8080;
	localparam logic [15:0] TOGGLE_MASK = 16'h4444;
	localparam logic [15:0] CHECK_LO    = 16'h0044;
	localparam logic [15:0] CHECK_HI    = 16'h4400;
	localparam int DQ5_LO_BIT = 5;
	localparam int DQ5_HI_BIT = 13;

	localparam logic [15:0] ERASE_SEQ [6] = '{FL_UNLOCK1, FL_UNLOCK2, FL_ERASE,
		FL_UNLOCK1, FL_UNLOCK2, FL_CHIP_ERS};
	localparam logic [15:0] PROG_SEQ [3] = '{FL_UNLOCK1, FL_UNLOCK2, FL_PROGRAM};

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_PROG  = 2'd1,
		MODE_ERASE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		SEQ_ERASE  = 3'd0,
		SEQ_PROG   = 3'd1,
		SEQ_RESET  = 3'd2,
		SEQ_STATUS = 3'd3,
		SEQ_ABORT  = 3'd4
	} seq_t;

	typedef struct packed {
		seq_t        seq;
		logic [2:0]  status;
		logic [15:0] data;
	} job_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [ADDR_W-1:0] word_offset;
		logic [15:0]       write_data;
		logic [15:0]       read_first;
		logic [15:0]       read_second;
	} item_t;

	typedef struct packed {
		logic              result_kind;
		logic [ADDR_W-1:0] bus_offset;
		logic [15:0]       bus_data;
		logic [2:0]        status_code;
		logic              last_result;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/nfps_front.sv
// nfps_front: accepts commands and polls, tracks flash mode, classifies each beat into a job
`default_nettype none
module nfps_front import nfps_pkg::*; #(
	parameter int WORD_ADDR_BITS = WORD_ADDR_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [LIMIT_W-1:0]        cfg_wdata,
	input  wire logic                      accept,
	input  wire item_t                     item,
	output job_t                           job,
	output logic [WORD_ADDR_BITS-1:0]      job_off
);

	logic [LIMIT_W-1:0] limit_q;
	mode_t              mode_q, mode_d;
	logic [1:0]         watch_q, watch_d;
	logic [15:0]        exp_q, exp_d;
	logic [LIMIT_W-1:0] pc_q, pc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			watch_q <= 2'b11;
			exp_q   <= '0;
			pc_q    <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			watch_q <= watch_d;
			exp_q   <= exp_d;
			pc_q    <= pc_d;
		end
	end

	assign job_off = item.word_offset[WORD_ADDR_BITS-1:0];

	always_comb begin
		logic [LIMIT_W-1:0] pc_dec;
		logic [15:0]        chk;
		logic [1:0]         w;
		mode_d     = mode_q;
		watch_d    = watch_q;
		exp_d      = exp_q;
		pc_d       = pc_q;
		job.seq    = SEQ_STATUS;
		job.status = ST_REJECT;
		job.data   = item.write_data;
		pc_dec     = (pc_q != '0) ? pc_q - LIMIT_W'(1) : pc_q;
		w          = watch_q;
		chk        = '0;
		if (w[0] && item.read_second[DQ5_LO_BIT]) begin
			w[0] = 1'b0;
			chk  = chk | CHECK_LO;
		end
		if (w[1] && item.read_second[DQ5_HI_BIT]) begin
			w[1] = 1'b0;
			chk  = chk | CHECK_HI;
		end
		case (item.command)
			CMD_ERASE: begin
				job.seq = SEQ_ERASE;
				mode_d  = MODE_ERASE;
				watch_d = 2'b11;
			end
			CMD_PROGRAM: begin
				job.seq = SEQ_PROG;
				exp_d   = item.write_data & DQ7_MASK;
				pc_d    = limit_q;
				mode_d  = MODE_PROG;
			end
			CMD_RESET: begin
				job.seq = SEQ_RESET;
				mode_d  = MODE_IDLE;
			end
			CMD_POLL: begin
				case (mode_q)
					MODE_PROG: begin
						pc_d = pc_dec;
						if (pc_dec == '0) begin
							job.status = ST_TIMEOUT;
							mode_d     = MODE_IDLE;
						end else if ((item.read_first & DQ7_MASK) == exp_q) begin
							job.status = ST_WORD_DONE;
							mode_d     = MODE_IDLE;
						end else begin
							job.status = ST_BUSY;
						end
					end
					MODE_ERASE: begin
						if (((item.read_first ^ item.read_second) & TOGGLE_MASK) == '0) begin
							job.status = ST_ERASE_DONE;
							mode_d     = MODE_IDLE;
						end else begin
							watch_d = w;
							if (((item.read_first ^ item.read_second) & chk) != '0) begin
								// DQ5 timeout with the chip still toggling: abort
								job.seq = SEQ_ABORT;
								mode_d  = MODE_IDLE;
							end else begin
								job.status = ST_BUSY;
							end
						end
					end
					default: job.status = ST_REJECT;
				endcase
			end
			default: job.status = ST_REJECT;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/nfps_jobq.sv
// nfps_jobq: small job queue between the command front and the bus write back end
`default_nettype none
module nfps_jobq import nfps_pkg::*; #(
	parameter int OFF_BITS = WORD_ADDR_BITS_DEF,
	parameter int DEPTH    = JOBQ_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire job_t                wr_job,
	input  wire logic [OFF_BITS-1:0] wr_off,
	output logic                     full,
	input  wire logic                rd_en,
	output logic                     rd_valid,
	output job_t                     rd_job,
	output logic [OFF_BITS-1:0]      rd_off
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t                job_mem [DEPTH];
	logic [OFF_BITS-1:0] off_mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_wr, do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_job   = job_mem[rd_ptr_q];
	assign rd_off   = off_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			job_mem[wr_ptr_q] <= wr_job;
			off_mem[wr_ptr_q] <= wr_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/nfps_back.sv
// nfps_back: turns each job into bus write and status beats, one per cycle unless stalled
`default_nettype none
module nfps_back import nfps_pkg::*; #(
	parameter int OFF_BITS = WORD_ADDR_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire job_t                q_job,
	input  wire logic [OFF_BITS-1:0] q_off,
	output logic                     q_take,
	output logic                     empty,
	input  wire logic                pop,
	output result_t                  result
);

	logic                cur_valid_q;
	job_t                cur_job_q;
	logic [OFF_BITS-1:0] cur_off_q;
	logic [2:0]          beat_q;
	logic                out_valid_q;
	result_t             out_q;
	result_t             beat;
	logic                advance;

	assign empty   = !out_valid_q;
	assign result  = out_q;
	assign advance = cur_valid_q && (!out_valid_q || pop);
	assign q_take  = q_valid && (!cur_valid_q || (advance && beat.last_result));

	always_comb begin
		beat.result_kind = KIND_WRITE;
		beat.bus_offset  = '0;
		beat.bus_data    = '0;
		beat.status_code = ST_NONE;
		beat.last_result = 1'b0;
		case (cur_job_q.seq)
			SEQ_ERASE: begin
				beat.bus_data    = (beat_q < 3'd6) ? ERASE_SEQ[beat_q] : FL_CHIP_ERS;
				beat.last_result = (beat_q == 3'd5);
			end
			SEQ_PROG: begin
				if (beat_q == 3'd3) begin
					beat.bus_offset  = ADDR_W'(cur_off_q);
					beat.bus_data    = cur_job_q.data;
					beat.last_result = 1'b1;
				end else begin
					beat.bus_data = (beat_q < 3'd3) ? PROG_SEQ[beat_q[1:0]] : FL_PROGRAM;
				end
			end
			SEQ_RESET: begin
				beat.bus_data    = FL_RESET;
				beat.last_result = 1'b1;
			end
			SEQ_ABORT: begin
				// reset write first, then the error report
				if (beat_q == 3'd0) begin
					beat.bus_data = FL_RESET;
				end else begin
					beat.result_kind = KIND_STATUS;
					beat.status_code = ST_ERASE_ERR;
					beat.last_result = 1'b1;
				end
			end
			default: begin
				beat.result_kind = KIND_STATUS;
				beat.status_code = cur_job_q.status;
				beat.last_result = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			cur_job_q <= q_job;
			cur_off_q <= q_off;
		end
		if (advance) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_take) begin
				cur_valid_q <= 1'b1;
			end else if (advance && beat.last_result) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				beat_q <= beat.last_result ? 3'd0 : beat_q + 3'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/nor_flash_program_erase_sequencer.sv
// nor_flash_program_erase_sequencer: top level, front end, job queue and beat generator
// A command beat is accepted every cycle while the job queue has room; its job is queued,
// then taken into the back end, whose output register drives its first result onto the port.
// Each command yields 1 to 6 result beats, emitted one per cycle by the back end while
// its output register is empty or popped; the next job is taken only with the last beat.
// Asynchronous active-low reset: mode idle, both DQ5 watched, queue and output empty.
`default_nettype none
module nor_flash_program_erase_sequencer import nfps_pkg::*; #(
	parameter int WORD_ADDR_BITS = WORD_ADDR_BITS_DEF,
	parameter int JOBQ_DEPTH     = JOBQ_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire item_t              item,
	output logic                    empty,
	input  wire logic               pop,
	output result_t                 result,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata
);

	logic                      accept;
	job_t                      f_job;
	logic [WORD_ADDR_BITS-1:0] f_off;
	logic                      q_valid, q_take;
	job_t                      q_job;
	logic [WORD_ADDR_BITS-1:0] q_off;

	assign accept = push && !full;

	nfps_front #(.WORD_ADDR_BITS(WORD_ADDR_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.job       (f_job),
		.job_off   (f_off)
	);

	nfps_jobq #(.OFF_BITS(WORD_ADDR_BITS), .DEPTH(JOBQ_DEPTH)) u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_job   (f_job),
		.wr_off   (f_off),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.rd_off   (q_off)
	);

	nfps_back #(.OFF_BITS(WORD_ADDR_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_off   (q_off),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == KIND_STATUS) |-> result.last_result)
		else $error("status beat not marked last");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == KIND_STATUS) |->
		(result.bus_offset == '0 && result.bus_data == '0))
		else $error("status beat carries bus offset or data");

	a_write_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == KIND_WRITE) |-> result.status_code == ST_NONE)
		else $error("bus write beat carries a status code");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("back end took a job from an empty queue");

endmodule
`default_nettype wire
